[rtl/fcm_pkg.sv]
// Package for the frequency channel monitor.
// Holds field widths, status and register index codes, reset values and shared structs.
// No dependencies.
package fcm_pkg;

	localparam int unsigned PULSE_W        = 24;
	localparam int unsigned TAG_W          = 4;
	localparam int unsigned VAL_W          = 32;
	localparam int unsigned ST_W           = 2;
	localparam int unsigned DB_W           = 31;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 32;
	localparam int unsigned IN_TDATA_W     = 32;
	localparam int unsigned OUT_TDATA_W    = 40;
	localparam int unsigned COUNT_BITS_DEF = 24;
	localparam int unsigned ROUND_SHIFT    = 8;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_WARN  = 2'd1,
		ST_ALARM = 2'd2,
		ST_MASK  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN       = 3'd0,
		REG_OFFSET     = 3'd1,
		REG_WARN_LOW   = 3'd2,
		REG_WARN_HIGH  = 3'd3,
		REG_ALARM_LOW  = 3'd4,
		REG_ALARM_HIGH = 3'd5,
		REG_DEADBAND   = 3'd6,
		REG_MASKED     = 3'd7
	} cfg_idx_t;

	localparam logic signed [VAL_W-1:0] WARN_LOW_RST   = 32'sd1310720;
	localparam logic signed [VAL_W-1:0] WARN_HIGH_RST  = 32'sd2621440;
	localparam logic signed [VAL_W-1:0] ALARM_LOW_RST  = 32'sd983040;
	localparam logic signed [VAL_W-1:0] ALARM_HIGH_RST = 32'sd2949120;
	localparam logic [DB_W-1:0]         DEADBAND_RST   = 31'd65536;
	localparam logic signed [VAL_W-1:0] REPORTED_RST   = 32'sh00FF_0000;

	typedef struct packed {
		logic signed [VAL_W-1:0] gain;
		logic signed [VAL_W-1:0] offset;
		logic signed [VAL_W-1:0] warn_low;
		logic signed [VAL_W-1:0] warn_high;
		logic signed [VAL_W-1:0] alarm_low;
		logic signed [VAL_W-1:0] alarm_high;
		logic [DB_W-1:0]         deadband;
		logic                    masked;
	} cfg_t;

	typedef struct packed {
		logic                    valid;
		logic [TAG_W-1:0]        tag;
		logic signed [VAL_W-1:0] value;
	} val_t;

endpackage

[rtl/fcm_cfg.sv]
// Configuration register file of the frequency channel monitor.
// Depends on fcm_pkg for the register index codes, reset values and cfg_t.
module fcm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output fcm_pkg::cfg_t                      cfg
);
	import fcm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain       <= '0;
			cfg_q.offset     <= '0;
			cfg_q.warn_low   <= WARN_LOW_RST;
			cfg_q.warn_high  <= WARN_HIGH_RST;
			cfg_q.alarm_low  <= ALARM_LOW_RST;
			cfg_q.alarm_high <= ALARM_HIGH_RST;
			cfg_q.deadband   <= DEADBAND_RST;
			cfg_q.masked     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				REG_GAIN:       cfg_q.gain       <= $signed(cfg_data);
				REG_OFFSET:     cfg_q.offset     <= $signed(cfg_data);
				REG_WARN_LOW:   cfg_q.warn_low   <= $signed(cfg_data);
				REG_WARN_HIGH:  cfg_q.warn_high  <= $signed(cfg_data);
				REG_ALARM_LOW:  cfg_q.alarm_low  <= $signed(cfg_data);
				REG_ALARM_HIGH: cfg_q.alarm_high <= $signed(cfg_data);
				REG_DEADBAND:   cfg_q.deadband   <= cfg_data[DB_W-1:0];
				REG_MASKED:     cfg_q.masked     <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/fcm_scale.sv]
// Scaling pipeline: input register, gain multiply, round to Q16.16, offset add and saturate.
// Depends on fcm_pkg for field widths and val_t.
module fcm_scale #(
	parameter int unsigned COUNT_BITS = fcm_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [fcm_pkg::PULSE_W-1:0]          pulse_count,
	input  logic [fcm_pkg::TAG_W-1:0]            channel_tag,
	input  logic signed [fcm_pkg::VAL_W-1:0]     gain,
	input  logic signed [fcm_pkg::VAL_W-1:0]     offset,
	output fcm_pkg::val_t                        val,
	input  logic                                 val_ready
);
	import fcm_pkg::*;

	localparam int unsigned PW = COUNT_BITS + VAL_W + 1;
	localparam int unsigned QW = PW - ROUND_SHIFT;
	localparam int unsigned SW = QW + 2;

	logic                    v_s1, v_s2, v_s3;
	logic                    adv1, adv2, adv3;
	logic [COUNT_BITS-1:0]   cnt;
	logic [COUNT_BITS-1:0]   cnt_s1;
	logic [TAG_W-1:0]        tag_s1, tag_s2, tag_s3;
	logic signed [PW-1:0]    prod;
	logic signed [PW-1:0]    prod_s2;
	logic signed [SW-1:0]    sum;
	logic signed [VAL_W-1:0] sat;
	logic signed [VAL_W-1:0] val_s3;

	assign adv3     = !v_s3 || val_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < COUNT_BITS; i++) begin
			if (i < PULSE_W) begin
				cnt[i] = pulse_count[i];
			end
		end
	end

	assign prod = gain * $signed({1'b0, cnt_s1});

	always_comb begin
		sum = $signed({{(SW-QW){prod_s2[PW-1]}}, prod_s2[PW-1:ROUND_SHIFT]})
			+ $signed({{(SW-1){1'b0}}, prod_s2[ROUND_SHIFT-1]})
			+ $signed({{(SW-VAL_W){offset[VAL_W-1]}}, offset});
		if (sum[SW-1:VAL_W-1] == {(SW-VAL_W+1){sum[SW-1]}}) begin
			sat = sum[VAL_W-1:0];
		end else if (sum[SW-1]) begin
			sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cnt_s1 <= cnt;
			tag_s1 <= channel_tag;
		end
		if (adv2) begin
			prod_s2 <= prod;
			tag_s2  <= tag_s1;
		end
		if (adv3) begin
			val_s3 <= sat;
			tag_s3 <= tag_s2;
		end
	end

	assign val.valid = v_s3;
	assign val.tag   = tag_s3;
	assign val.value = val_s3;

endmodule

[rtl/fcm_report.sv]
// Classification, report decision and output register of the frequency channel monitor.
// Depends on fcm_pkg for status codes, cfg_t and val_t.
module fcm_report (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fcm_pkg::val_t                     val,
	output logic                              val_ready,
	input  fcm_pkg::cfg_t                     cfg,
	output logic                              rep_valid,
	input  logic                              rep_ready,
	output logic [fcm_pkg::TAG_W-1:0]         rep_tag,
	output logic signed [fcm_pkg::VAL_W-1:0]  rep_value,
	output fcm_pkg::status_t                  rep_status,
	output logic                              rep_last
);
	import fcm_pkg::*;

	status_t                 status_now_q;
	logic signed [VAL_W-1:0] reported_q;
	logic                    rep_valid_q;
	logic [TAG_W-1:0]        rep_tag_q;
	logic signed [VAL_W-1:0] rep_value_q;
	status_t                 rep_status_q;

	status_t                 cls;
	status_t                 new_st;
	logic                    chg;
	logic                    beyond;
	logic                    emit;
	logic                    adv;
	logic signed [VAL_W:0]   diff;
	logic [VAL_W:0]          mag;

	assign adv       = !rep_valid_q || rep_ready;
	assign val_ready = adv;

	always_comb begin
		cls = ST_OK;
		if (val.value > cfg.warn_high || val.value < cfg.warn_low) begin
			if (val.value > cfg.alarm_high || val.value < cfg.alarm_low) begin
				cls = ST_ALARM;
			end else begin
				cls = ST_WARN;
			end
		end
		new_st = cfg.masked ? ST_MASK : cls;
		chg    = (new_st != status_now_q);
		diff   = $signed({val.value[VAL_W-1], val.value})
			- $signed({reported_q[VAL_W-1], reported_q});
		mag    = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
		beyond = !chg && (mag > {2'b00, cfg.deadband});
		emit   = chg || beyond;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_now_q <= ST_OK;
			reported_q   <= REPORTED_RST;
			rep_valid_q  <= 1'b0;
		end else if (adv) begin
			rep_valid_q <= val.valid && emit;
			if (val.valid) begin
				status_now_q <= new_st;
				if (emit) begin
					reported_q <= val.value;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rep_tag_q    <= val.tag;
			rep_value_q  <= val.value;
			rep_status_q <= new_st;
		end
	end

	assign rep_valid  = rep_valid_q;
	assign rep_tag    = rep_tag_q;
	assign rep_value  = rep_value_q;
	assign rep_status = rep_status_q;
	assign rep_last   = 1'b1;

endmodule

[rtl/frequency_channel_monitor.sv]
// Frequency channel monitor top level: gated pulse count to scaled value with status reports.
// Depends on fcm_pkg, fcm_cfg, fcm_scale and fcm_report.
//
//   channel  direction  transaction
//   s_*      in         one pulse count with its channel tag
//   m_*      out        one report: tag, scaled value, status
//   cfg_*    in         one register write, index and data
//
// One item accepted per cycle while the output is not stalled.
// An item gives at most one report, so tlast is set on every report.
// An item passes the three-stage scaling pipeline and then the output register.
// Stages advance independently, so bubbles fill while m_tready is low.
// Reset clears control and status state; no clearing pass is needed.
module frequency_channel_monitor #(
	parameter int unsigned COUNT_BITS = fcm_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [fcm_pkg::IN_TDATA_W-1:0]     s_tdata,   // pulse_count, channel_tag
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [fcm_pkg::OUT_TDATA_W-1:0]    m_tdata,   // report_tag, scaled_value, status_code
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fcm_pkg::*;

	cfg_t                    cfg;
	val_t                    val;
	logic                    val_ready;
	logic [TAG_W-1:0]        rep_tag;
	logic signed [VAL_W-1:0] rep_value;
	status_t                 rep_status;

	fcm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fcm_scale #(
		.COUNT_BITS (COUNT_BITS)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.pulse_count (s_tdata[PULSE_W-1:0]),
		.channel_tag (s_tdata[PULSE_W+TAG_W-1:PULSE_W]),
		.gain        (cfg.gain),
		.offset      (cfg.offset),
		.val         (val),
		.val_ready   (val_ready)
	);

	fcm_report u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.val        (val),
		.val_ready  (val_ready),
		.cfg        (cfg),
		.rep_valid  (m_tvalid),
		.rep_ready  (m_tready),
		.rep_tag    (rep_tag),
		.rep_value  (rep_value),
		.rep_status (rep_status),
		.rep_last   (m_tlast)
	);

	assign m_tdata = {{(OUT_TDATA_W-TAG_W-VAL_W-ST_W){1'b0}}, rep_status, rep_value, rep_tag};

endmodule

[rtl/fcm_checker.sv]
// Port checker for the frequency channel monitor, bound to the top level.
// Depends on fcm_pkg for port widths.
module fcm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [fcm_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tlast
);
	import fcm_pkg::*;

	localparam int unsigned USED_W = TAG_W + VAL_W + ST_W;

	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("report changed while stalled");

	a_one_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tlast)
		else $error("report without tlast");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:USED_W] == '0)
		else $error("tdata padding not zero");

	a_no_report_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("report straight out of reset");

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting report");

endmodule

bind frequency_channel_monitor fcm_checker u_fcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
